>>> design/glw_pkg.sv
// ----------------------------------------------------------------------------
// glw_pkg
// Types, codes and constants shared by the greedy line wrap block.
// ----------------------------------------------------------------------------
package glw_pkg;

  localparam int DEF_MAX_CHARS = 64;

  localparam int CW_W     = 12;  // char width, Q8.4
  localparam int LW_W     = 12;  // line width, whole pixels
  localparam int TGT_W    = 16;  // line width in Q12.4
  localparam int LSTART_W = 6;
  localparam int LLEN_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SYM  = 1'b1;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 12'd320;

  localparam logic [1:0] CLS_ALLOWED  = 2'd1;
  localparam logic [1:0] CLS_REQUIRED = 2'd2;

  typedef struct packed {
    logic [CW_W-1:0] char_width;
    logic [1:0]      break_class;
    logic            is_space;
    logic            is_newline;
    logic            last_char;
  } in_item_t;

  typedef struct packed {
    logic [LSTART_W-1:0] line_start;
    logic [LLEN_W-1:0]   line_length;
    logic                last_line;
  } out_item_t;

  typedef struct packed {
    logic            is_newline;
    logic            is_space;
    logic [1:0]      break_class;
    logic [CW_W-1:0] char_width;
  } char_ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT
  } glw_state_t;

endpackage

>>> design/glw_char_mem.sv
// ----------------------------------------------------------------------------
// glw_char_mem
// Character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module glw_char_mem
  import glw_pkg::*;
#(
  parameter int MAX_CHARS = DEF_MAX_CHARS,
  parameter int AW        = $clog2(MAX_CHARS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  char_ent_t     wdata,
  input  logic [AW-1:0] raddr,
  output char_ent_t     rdata_r
);

  char_ent_t mem [MAX_CHARS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> design/glw_acc_unit.sv
// ----------------------------------------------------------------------------
// glw_acc_unit
// Shared accumulate-and-compare unit: running width plus one character,
// checked against the line target.
// ----------------------------------------------------------------------------
module glw_acc_unit
  import glw_pkg::*;
#(
  parameter int ACC_W = 18
) (
  input  logic [ACC_W-1:0] acc,
  input  logic [CW_W-1:0]  char_width,
  input  logic [TGT_W-1:0] target,
  output logic [ACC_W-1:0] sum,
  output logic             over
);

  localparam int CMP_W = (ACC_W > TGT_W) ? ACC_W : TGT_W;

  assign sum  = acc + ACC_W'(char_width);
  assign over = CMP_W'(sum) > CMP_W'(target);

endmodule

>>> design/glw_seq.sv
// ----------------------------------------------------------------------------
// glw_seq
// Load and layout sequencer: stores characters, scans each line in word or
// symbol mode through the shared accumulate unit, registers line results.
// ----------------------------------------------------------------------------
module glw_seq
  import glw_pkg::*;
#(
  parameter int MAX_CHARS = DEF_MAX_CHARS,
  parameter int AW        = $clog2(MAX_CHARS),
  parameter int CW        = $clog2(MAX_CHARS + 1),
  parameter int ACC_W     = $clog2(MAX_CHARS) + CW_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             split_sym,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output char_ent_t        mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  char_ent_t        mem_rdata,
  output logic [ACC_W-1:0] acc_op,
  input  logic [ACC_W-1:0] acc_sum,
  input  logic             acc_over
);

  glw_state_t       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    off_r, off_nxt;
  logic [AW-1:0]    brk_r, brk_nxt;
  logic             have_brk_r, have_brk_nxt;
  logic             sym_r, sym_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CW-1:0]    len_r, len_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic          in_acc;
  logic          last_pos;
  logic [CW-1:0] pos_len, brk_len, cut_len, end_pos;
  logic          line_done;
  logic          out_free;
  logic          text_end;
  logic          word_fit;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign last_pos = (CW'(pos_r) + 1'b1) == cnt_r;
  assign pos_len  = CW'(pos_r) - CW'(off_r) + 1'b1;
  assign brk_len  = CW'(brk_r) - CW'(off_r) + 1'b1;
  assign cut_len  = CW'(pos_r) - CW'(off_r);
  assign end_pos  = CW'(off_r) + len_r;
  assign text_end = end_pos >= cnt_r;
  assign out_free = !out_valid_r || out_ready;
  assign word_fit = !acc_over || mem_rdata.is_space;

  assign acc_op    = acc_r;
  assign mem_raddr = pos_r;
  assign mem_waddr = cnt_r[AW-1:0];
  assign mem_wdata = '{is_newline:  in_data.is_newline,
                       is_space:    in_data.is_space,
                       break_class: in_data.break_class,
                       char_width:  in_data.char_width};

  // line end decision in EVAL
  always_comb begin
    line_done = 1'b0;
    if (!sym_r) begin
      if (word_fit) begin
        line_done = (mem_rdata.break_class == CLS_REQUIRED);
      end else begin
        line_done = have_brk_r;
      end
    end else begin
      line_done = mem_rdata.is_newline || ((acc_r != '0) && acc_over) || last_pos;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.last_char) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        state_nxt = line_done ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = text_end ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we        = 1'b0;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    off_nxt       = off_r;
    brk_nxt       = brk_r;
    have_brk_nxt  = have_brk_r;
    sym_nxt       = sym_r;
    acc_nxt       = acc_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_CHARS)) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          off_nxt      = '0;
          pos_nxt      = '0;
          acc_nxt      = '0;
          have_brk_nxt = 1'b0;
          sym_nxt      = split_sym;
        end
      end
      ST_READ: begin
      end
      ST_EVAL: begin
        if (!sym_r) begin
          if (word_fit) begin
            if (mem_rdata.break_class == CLS_REQUIRED) begin
              len_nxt = pos_len;
            end else begin
              if (mem_rdata.break_class == CLS_ALLOWED) begin
                brk_nxt      = pos_r;
                have_brk_nxt = 1'b1;
              end
              if (last_pos) begin
                sym_nxt = 1'b1;
                pos_nxt = off_r;
                acc_nxt = '0;
              end else begin
                pos_nxt = pos_r + 1'b1;
                acc_nxt = acc_sum;
              end
            end
          end else if (have_brk_r) begin
            len_nxt = brk_len;
          end else begin
            sym_nxt = 1'b1;
            pos_nxt = off_r;
            acc_nxt = '0;
          end
        end else begin
          if (mem_rdata.is_newline) begin
            len_nxt = pos_len;
          end else if ((acc_r != '0) && acc_over) begin
            len_nxt = cut_len;
          end else begin
            acc_nxt = acc_sum;
            if (last_pos) begin
              len_nxt = pos_len;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{line_start:  LSTART_W'(off_r),
                            line_length: LLEN_W'(len_r),
                            last_line:   text_end};
          if (text_end) begin
            cnt_nxt = '0;
          end else begin
            off_nxt      = end_pos[AW-1:0];
            pos_nxt      = end_pos[AW-1:0];
            acc_nxt      = '0;
            have_brk_nxt = 1'b0;
            sym_nxt      = split_sym;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    off_r      <= off_nxt;
    brk_r      <= brk_nxt;
    have_brk_r <= have_brk_nxt;
    sym_r      <= sym_nxt;
    acc_r      <= acc_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/greedy_line_wrap.sv
// ----------------------------------------------------------------------------
// greedy_line_wrap
// Greedy line breaking of a short text into line spans.
// ----------------------------------------------------------------------------
// Usage: characters arrive on in_valid/in_ready/in_data, one transaction per
// cycle while loading. The transaction with last_char set starts the layout;
// in_ready stays low until the last line span has been handed to the output
// register. Line spans leave on out_valid/out_ready/out_data in text order,
// last_line set on the final one. Characters beyond MAX_CHARS are dropped.
// Layout steps: each store read (READ) is followed by one pass through the
// shared accumulate/compare unit (EVAL), and each line ends by loading the
// output register (EMIT). Word mode that falls back to symbol mode reads the
// line again from its start, and characters read past a split are read again
// for the next line.
// The output register lets the next line be scanned while a span waits; a
// stalled receiver holds the sequencer only when a second span is ready.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect next cycle and
// belong between texts. Reset restores line_width 320, word mode, and an
// empty store; the store contents need no clearing.
// ----------------------------------------------------------------------------
module greedy_line_wrap
  import glw_pkg::*;
#(
  parameter int MAX_CHARS = DEF_MAX_CHARS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LW_W-1:0]      cfg_wdata
);

  localparam int AW    = $clog2(MAX_CHARS);
  localparam int CW    = $clog2(MAX_CHARS + 1);
  localparam int ACC_W = $clog2(MAX_CHARS) + CW_W;

  logic [LW_W-1:0]  line_width_r, line_width_nxt;
  logic             split_sym_r, split_sym_nxt;
  logic [TGT_W-1:0] target;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  char_ent_t        mem_wdata, mem_rdata;
  logic [ACC_W-1:0] acc_op, acc_sum;
  logic             acc_over;

  always_comb begin
    line_width_nxt = line_width_r;
    split_sym_nxt  = split_sym_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: line_width_nxt = cfg_wdata;
        REG_SPLIT_SYM:  split_sym_nxt  = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      split_sym_r  <= 1'b0;
    end else begin
      line_width_r <= line_width_nxt;
      split_sym_r  <= split_sym_nxt;
    end
  end

  assign target = {line_width_r, 4'b0000};

  glw_char_mem #(
    .MAX_CHARS (MAX_CHARS),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  glw_acc_unit #(
    .ACC_W (ACC_W)
  ) u_acc (
    .acc        (acc_op),
    .char_width (mem_rdata.char_width),
    .target     (target),
    .sum        (acc_sum),
    .over       (acc_over)
  );

  glw_seq #(
    .MAX_CHARS (MAX_CHARS),
    .AW        (AW),
    .CW        (CW),
    .ACC_W     (ACC_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .split_sym (split_sym_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .acc_op    (acc_op),
    .acc_sum   (acc_sum),
    .acc_over  (acc_over)
  );

endmodule

>>> dv/glw_checker.sv
// ----------------------------------------------------------------------------
// glw_checker
// Watches the character, line span and register ports of greedy_line_wrap,
// predicts the line spans of every text and compares them in order.
// ----------------------------------------------------------------------------
module glw_checker
  import glw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LW_W-1:0]      cfg_wdata,
  output int                   fail_count,
  output int                   lines_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTED = 10;

  char_ent_t       text_buf [DEF_MAX_CHARS];
  int unsigned     char_total;
  logic [LW_W-1:0] width_reg;
  logic            split_reg;
  out_item_t       span_q [$];
  int              span_no;

  // Word mode: 0 means fall back to symbol mode.
  function automatic int unsigned word_span(int unsigned off, int unsigned tgt);
    logic [17:0] acc;
    int unsigned brk;
    bit          have_brk;
    int unsigned p;
    acc      = '0;
    brk      = 0;
    have_brk = 1'b0;
    for (p = off; p < char_total; p++) begin
      acc += text_buf[p].char_width;
      if (acc <= tgt || text_buf[p].is_space) begin
        if (text_buf[p].break_class == CLS_REQUIRED) return p - off + 1;
        if (text_buf[p].break_class == CLS_ALLOWED) begin
          brk      = p;
          have_brk = 1'b1;
        end
      end else if (have_brk) begin
        return brk - off + 1;
      end else begin
        return 0;
      end
    end
    return 0;
  endfunction

  function automatic int unsigned symbol_span(int unsigned off, int unsigned tgt);
    int unsigned dx;
    int unsigned p;
    dx = 0;
    for (p = off; p < char_total; p++) begin
      if (text_buf[p].is_newline) return p - off + 1;
      if (dx > 0 && dx + text_buf[p].char_width > tgt) return p - off;
      dx += text_buf[p].char_width;
    end
    return char_total - off;
  endfunction

  function automatic void layout_text();
    int unsigned tgt;
    int unsigned off;
    int unsigned len;
    out_item_t   span;
    tgt = width_reg * 16;
    off = 0;
    while (off < char_total) begin
      len = split_reg ? 0 : word_span(off, tgt);
      if (len == 0) len = symbol_span(off, tgt);
      if (len == 0) len = 1;
      span.line_start  = off[LSTART_W-1:0];
      span.line_length = len[LLEN_W-1:0];
      span.last_line   = (off + len >= char_total);
      span_q = {span_q, span};
      off += len;
    end
  endfunction

  function automatic void accept_char(in_item_t it);
    if (char_total < DEF_MAX_CHARS) begin
      text_buf[char_total].char_width  = it.char_width;
      text_buf[char_total].break_class = it.break_class;
      text_buf[char_total].is_space    = it.is_space;
      text_buf[char_total].is_newline  = it.is_newline;
      char_total++;
    end
    if (it.last_char) begin
      layout_text();
      char_total = 0;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      char_total = 0;
      width_reg  = LINE_WIDTH_RST;
      split_reg  = 1'b0;
      span_q.delete();
      span_no    = 0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) accept_char(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_WIDTH: width_reg = cfg_wdata;
          REG_SPLIT_SYM:  split_reg = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (span_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("span %0d: unexpected transaction start %0d len %0d last %0b",
                     span_no, got.line_start, got.line_length, got.last_line);
        end else begin
          want = span_q.pop_front();
          if (got.line_start !== want.line_start || got.line_length !== want.line_length ||
              got.last_line !== want.last_line) begin
            fail_count++;
            if (fail_count <= MAX_REPORTED)
              $display({"span %0d: expected start %0d len %0d last %0b, ",
                        "got start %0d len %0d last %0b"},
                       span_no, want.line_start, want.line_length, want.last_line,
                       got.line_start, got.line_length, got.last_line);
          end
        end
        span_no++;
      end
    end
    lines_pending <= span_q.size();
  end

endmodule

>>> dv/greedy_line_wrap_tb.sv
// ----------------------------------------------------------------------------
// greedy_line_wrap_tb
// Feeds texts to greedy_line_wrap under several register settings and
// handshake pressure; the line spans are checked by glw_checker.
// ----------------------------------------------------------------------------
module greedy_line_wrap_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import glw_pkg::*;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_RSVD = 2'd3;
  localparam int RANDOM_ITEMS = 250;
  localparam int SETTLE       = 8;
  localparam int LIMIT        = 400000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
  logic [LW_W-1:0]      cfg_wdata = '0;
  logic                 in_ready;
  logic                 out_valid;
  out_item_t            out_data;
  int                   fail_count;
  int                   lines_pending;

  int              idle_pct = 0;
  int              stall_pct = 0;
  int              wd_cycles = 0;
  logic [LW_W-1:0] cur_lw = LINE_WIDTH_RST;

  logic [LW_W-1:0] lw_set  [8] = '{12'd4095, 12'd0, 12'd40, 12'd0, 12'd4095, 12'd0,
                                   12'd12, 12'd0};
  logic            sym_set [8] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  greedy_line_wrap u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  glw_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .lines_pending (lines_pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_char(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (lines_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(logic [LW_W-1:0] lw, logic sym);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= lw;
    @(posedge clk);
    cfg_index <= REG_SPLIT_SYM;
    cfg_wdata <= LW_W'(sym);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lw = lw;
  endtask

  task automatic set_phase(int ph);
    case (ph)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 82; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 82; end
      default: begin idle_pct = 10; stall_pct = 10; end
    endcase
  endtask

  function automatic in_item_t mk(logic [CW_W-1:0] w, logic [1:0] cls, logic sp, logic nl,
                                  logic last);
    in_item_t it;
    it.char_width  = w;
    it.break_class = cls;
    it.is_space    = sp;
    it.is_newline  = nl;
    it.last_char   = last;
    return it;
  endfunction

  // Widths mostly scaled to the line so that lines hold several characters.
  function automatic logic [CW_W-1:0] pick_width();
    int unsigned span;
    span = (cur_lw * 16) / 3;
    if (span > 4095) span = 4095;
    case ($urandom_range(9))
      0: return CW_W'($urandom_range(4095));
      1: return '0;
      2: return '1;
      default: return CW_W'($urandom_range(span));
    endcase
  endfunction

  function automatic in_item_t pick_char(logic last);
    in_item_t    it;
    int unsigned r;
    it = '0;
    r  = $urandom_range(99);
    it.char_width = pick_width();
    if (r < 55) begin
      it.break_class = CLS_NONE;
    end else if (r < 75) begin
      it.break_class = CLS_ALLOWED;
      it.is_space    = 1'b1;
    end else if (r < 82) begin
      it.break_class = CLS_REQUIRED;
      it.is_newline  = 1'b1;
    end else if (r < 88) begin
      it.break_class = CLS_ALLOWED;
    end else begin
      it.break_class = 2'($urandom_range(CLS_RSVD));
      it.is_space    = 1'($urandom_range(1));
      it.is_newline  = 1'($urandom_range(1));
    end
    it.last_char = last;
    return it;
  endfunction

  initial begin
    while (wd_cycles < LIMIT) begin
      @(posedge clk);
      wd_cycles++;
    end
    $display("FAIL greedy_line_wrap");
    $finish;
  end

  initial begin
    int text_no;
    int len;
    int sent;
    int i;
    int sel;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: line 320 px, word mode
    send_char(mk(12'hFFF, CLS_NONE, 1'b0, 1'b0, 1'b1));
    // allowed break on the first character of a line
    send_char(mk(12'd3000, CLS_ALLOWED, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd3000, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd100, CLS_NONE, 1'b0, 1'b0, 1'b1));
    // overflowing space still fits, required break, reserved class
    send_char(mk(12'd4000, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'hFFF, CLS_ALLOWED, 1'b1, 1'b0, 1'b0));
    send_char(mk(12'd200, CLS_REQUIRED, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd300, CLS_RSVD, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd5, CLS_NONE, 1'b0, 1'b0, 1'b1));
    // no break in word mode, symbol fallback splits after newline
    send_char(mk(12'd2000, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd2000, CLS_NONE, 1'b0, 1'b1, 1'b0));
    send_char(mk(12'd2000, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd2000, CLS_NONE, 1'b0, 1'b0, 1'b1));
    send_char(mk(12'd0, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd0, CLS_ALLOWED, 1'b1, 1'b0, 1'b0));
    send_char(mk(12'd0, CLS_NONE, 1'b0, 1'b0, 1'b1));
    wait_idle();
    program_regs(12'd0, 1'b1);
    send_char(mk(12'd10, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd0, CLS_NONE, 1'b0, 1'b0, 1'b0));
    send_char(mk(12'd10, CLS_NONE, 1'b0, 1'b1, 1'b1));
    wait_idle();
    program_regs(12'hFFF, 1'b0);
    send_char(mk(12'hFFF, CLS_NONE, 1'b1, 1'b1, 1'b0));
    send_char(mk(12'hFFF, CLS_ALLOWED, 1'b0, 1'b0, 1'b1));

    text_no = 0;
    sent    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (text_no % 5 == 0) begin
        wait_idle();
        sel = (text_no / 5) % 8;
        if (sel == 7)
          program_regs(LW_W'($urandom_range(4095)), 1'($urandom_range(1)));
        else
          program_regs(lw_set[sel], sym_set[sel]);
      end
      set_phase(text_no % 4);
      if (text_no == 2)
        len = DEF_MAX_CHARS + 4;
      else if (text_no == 6)
        len = DEF_MAX_CHARS;
      else if ($urandom_range(9) == 0)
        len = $urandom_range(40, 13);
      else
        len = $urandom_range(12, 1);
      for (i = 0; i < len; i++) send_char(pick_char(i == len - 1));
      sent += len;
      text_no++;
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS greedy_line_wrap");
    end else begin
      $display("FAIL greedy_line_wrap");
    end
    $finish;
  end

endmodule
